[sv/psg_pkg.sv]
// package: types and constants for the tone and noise sound generator
`timescale 1ns / 1ps
`default_nettype none
package psg_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } psg_in_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } psg_out_t;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_TICK  = 1'b1;
  localparam logic [1:0] CFG_SKIP   = 2'd0;
  localparam logic [1:0] CFG_SCALE  = 2'd1;
  localparam logic [1:0] CFG_NOISE  = 2'd2;
  localparam logic [1:0] CFG_MASTER = 2'd3;
  localparam logic [2:0] CODE_NOISE_CTL = 3'd6;
  localparam logic [2:0] CODE_NOISE_VOL = 3'd7;
  localparam logic [6:0] MAX_SAMPLES = 7'd64;
  localparam logic [19:0] SKIP_RESET = 20'd11610;

  // datapath commands
  typedef struct packed {
    logic do_write;   // apply register byte
    logic do_tick;    // add cycles to accumulator
    logic do_advance; // draw one period, advance channels
  } psg_cmd_t;

  // datapath status
  typedef struct packed {
    logic can_draw;   // accumulator holds a full period and master volume nonzero
  } psg_sts_t;

endpackage
`default_nettype wire

[sv/psg_datapath.sv]
// datapath: channel state, accumulator, channel advance and mixer
`timescale 1ns / 1ps
`default_nettype none
module psg_datapath import psg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire psg_cmd_t    cmd,
  output psg_sts_t         sts,
  input  wire logic [7:0]  data_byte,
  input  wire logic [19:0] skip_cycles,
  input  wire logic [6:0]  tone_scale,
  input  wire logic [13:0] noise_base_period,
  input  wire logic [7:0]  master_volume,
  output logic [7:0]       sample
);

  logic [31:0] acc_r, acc_nxt;
  logic [15:0] hp_r [3];
  logic [31:0] ph_r [4];
  logic [3:0]  lvl_r, lvl_nxt;
  logic [3:0]  vol_r [4];
  logic [1:0]  rate_r;
  logic        white_r;
  logic [7:0]  latch_r;
  logic [14:0] lfsr_r, lfsr_nxt;
  logic [31:0] ph_nxt [4];
  logic [15:0] hp_nxt [3];
  logic [3:0]  vol_nxt [4];
  logic [1:0]  rate_nxt;
  logic        white_nxt;
  logic [7:0]  latch_nxt;

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [9:0]  raw;
  logic [16:0] prod;
  logic [19:0] nper;
  logic [23:0] nper_x;
  logic [39:0] nper_sh;
  logic [32:0] acc_sum;
  logic [9:0]  mix;
  logic [7:0]  mixc;
  logic [15:0] scaled;
  logic [1:0]  sel;

  assign sts.can_draw = (master_volume != 8'd0) && (acc_r >= {12'd0, skip_cycles});

  always_comb begin
    acc_nxt = acc_r;
    lvl_nxt = lvl_r;
    lfsr_nxt = lfsr_r;
    rate_nxt = rate_r;
    white_nxt = white_r;
    latch_nxt = latch_r;
    for (int i = 0; i < 4; i++) begin
      ph_nxt[i] = ph_r[i];
      vol_nxt[i] = vol_r[i];
    end
    for (int i = 0; i < 3; i++) hp_nxt[i] = hp_r[i];
    raw = {data_byte[5:0], latch_r[3:0]};
    prod = raw * tone_scale;
    sel = latch_r[6:5];
    acc_sum = {1'b0, acc_r} + {17'd0, data_byte, 8'd0};
    case (rate_r)
      2'd0:    nper = {6'd0, noise_base_period};
      2'd1:    nper = {5'd0, noise_base_period, 1'b0};
      2'd2:    nper = {4'd0, noise_base_period, 2'b0};
      default: nper = {4'd0, hp_r[0]};
    endcase
    nper_x = (!white_r && lvl_r[3]) ? ({4'd0, nper} * 24'd10) : {4'd0, nper};
    nper_sh = {8'd0, nper_x, 8'd0};
    if (cmd.do_write) begin
      if (data_byte[7]) begin
        case (data_byte[6:4])
          3'd0, 3'd2, 3'd4: latch_nxt = data_byte;
          3'd1: vol_nxt[2] = 4'd15 - data_byte[3:0];
          3'd3: vol_nxt[1] = 4'd15 - data_byte[3:0];
          3'd5: vol_nxt[0] = 4'd15 - data_byte[3:0];
          CODE_NOISE_CTL: begin
            rate_nxt = data_byte[1:0];
            white_nxt = data_byte[2];
          end
          default: vol_nxt[3] = 4'd15 - data_byte[3:0];
        endcase
      end else if (latch_r != 8'd0 && sel != 2'd3) begin
        hp_nxt[2'd2 - sel] = prod[16] ? 16'hFFFF : prod[15:0];
      end
    end
    if (cmd.do_tick) acc_nxt = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
    if (cmd.do_advance) begin
      acc_nxt = acc_r - {12'd0, skip_cycles};
      for (int i = 0; i < 3; i++) begin
        ph_nxt[i] = sat32(ph_r[i], {12'd0, skip_cycles});
        if ({8'd0, ph_nxt[i]} > {8'd0, hp_r[i], 8'd0}) begin
          ph_nxt[i] = ph_nxt[i] - {8'd0, hp_r[i], 8'd0};
          lvl_nxt[i] = ~lvl_r[i];
        end
      end
      if (vol_r[3] != 4'd0) begin
        ph_nxt[3] = sat32(ph_r[3], {12'd0, skip_cycles});
        if ({8'd0, ph_nxt[3]} > nper_sh) begin
          ph_nxt[3] = ph_nxt[3] - nper_sh[31:0];
          if (white_r) begin
            lvl_nxt[3] = lfsr_r[0];
            lfsr_nxt = {lfsr_r[0] ^ lfsr_r[1], lfsr_r[14:1]};
          end else begin
            lvl_nxt[3] = ~lvl_r[3];
          end
        end
      end
    end
  end

  // mixer works on the freshly advanced levels registered below
  always_comb begin
    mix = 10'd128;
    for (int i = 0; i < 4; i++) begin
      if (lvl_r[i]) mix = mix + {6'd0, vol_r[i]};
      else          mix = mix - {6'd0, vol_r[i]};
    end
    mixc = (mix > 10'd255) ? 8'd255 : mix[7:0];
    scaled = mixc * master_volume;
  end
  assign sample = scaled[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      lvl_r <= '0;
      lfsr_r <= 15'h4000;
      rate_r <= '0;
      white_r <= 1'b0;
      latch_r <= '0;
      for (int i = 0; i < 4; i++) begin
        ph_r[i] <= '0;
        vol_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) hp_r[i] <= {4'd0, SKIP_RESET[19:8]};
    end else begin
      acc_r <= acc_nxt;
      lvl_r <= lvl_nxt;
      lfsr_r <= lfsr_nxt;
      rate_r <= rate_nxt;
      white_r <= white_nxt;
      latch_r <= latch_nxt;
      for (int i = 0; i < 4; i++) begin
        ph_r[i] <= ph_nxt[i];
        vol_r[i] <= vol_nxt[i];
      end
      for (int i = 0; i < 3; i++) hp_r[i] <= hp_nxt[i];
    end
  end

endmodule
`default_nettype wire

[sv/psg_ctrl.sv]
// controller: request sequencing and sample output register
`timescale 1ns / 1ps
`default_nettype none
module psg_ctrl import psg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire psg_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output psg_out_t      out_data,
  output psg_cmd_t      cmd,
  input  wire psg_sts_t sts,
  input  wire logic [7:0] sample
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DRAW = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        ov_r, ov_nxt;
  psg_out_t    od_r, od_nxt;
  logic        in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.op == OP_WRITE) cmd.do_write = 1'b1;
          else begin
            cmd.do_tick = 1'b1;
            cnt_nxt = '0;
            state_nxt = S_DRAW;
          end
        end
      end
      S_DRAW: begin
        if (sts.can_draw && cnt_r < MAX_SAMPLES) begin
          cmd.do_advance = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt.sample = sample;
          od_nxt.last = !(sts.can_draw && cnt_r < MAX_SAMPLES);
          state_nxt = od_nxt.last ? S_IDLE : S_DRAW;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
    od_r <= od_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAX_SAMPLES)
    else $error("sample count over limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_advance |=> state_r == S_EMIT)
    else $error("advance not followed by emit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !out_stall) |=> out_valid)
    else $error("emit lost");

endmodule
`default_nettype wire

[sv/psg_tone_noise_sound_generator.sv]
// top level: tone and noise sound generator with configuration registers
// a register write is applied from idle; new requests stall until a tick ends
// each sample: advance in DRAW, then emit in EMIT, which waits while output stalls
// a tick with no sample goes from DRAW back to idle; up to 64 samples per tick
// samples come from the single channel-advance step of the datapath
// reset: synchronous active-low, restores register defaults and channel state
`timescale 1ns / 1ps
`default_nettype none
module psg_tone_noise_sound_generator import psg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire psg_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output psg_out_t        out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [19:0] cfg_data
);

  logic [19:0] skip_r;
  logic [6:0]  scale_r;
  logic [13:0] noise_r;
  logic [7:0]  master_r;
  psg_cmd_t    cmd;
  psg_sts_t    sts;
  logic [7:0]  sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RESET;
      scale_r <= 7'd8;
      noise_r <= 14'd100;
      master_r <= 8'd255;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SKIP:   skip_r <= cfg_data;
        CFG_SCALE:  scale_r <= cfg_data[6:0];
        CFG_NOISE:  noise_r <= cfg_data[13:0];
        CFG_MASTER: master_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  psg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cmd, .sts, .sample
  );

  psg_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .data_byte(in_data.data_byte),
    .skip_cycles(skip_r), .tone_scale(scale_r), .noise_base_period(noise_r),
    .master_volume(master_r), .sample
  );

endmodule
`default_nettype wire

[tb/psg_tone_noise_sound_generator_tb.sv]
// testbench: tone and noise sound generator, checked against a cycle-free predictor
`timescale 1ns / 1ps
`default_nettype none
module psg_tone_noise_sound_generator_tb;
  import psg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  psg_in_t in_data;
  logic out_valid;
  logic out_stall;
  psg_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [19:0] cfg_data;

  psg_tone_noise_sound_generator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [19:0] skip_q;
  logic [6:0] scale_q;
  logic [13:0] nbase_q;
  logic [7:0] mvol_q;
  logic [31:0] acc_q;
  logic [15:0] half_q [3];
  logic [31:0] phase_q [4];
  logic level_q [4];
  logic [3:0] vol_q [4];
  logic [1:0] rate_q;
  logic white_q;
  logic [7:0] latch_q;
  logic [14:0] shifter_q;

  psg_out_t sample_queue [$];
  int errors;
  int samples_seen;
  int ticks_sent;
  int writes_sent;
  int idle_cycles;
  bit stall_hold;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic int rnd_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic predictor_reset();
    skip_q = SKIP_RESET;
    scale_q = 7'd8;
    nbase_q = 14'd100;
    mvol_q = 8'd255;
    acc_q = '0;
    for (int i = 0; i < 3; i++) half_q[i] = 16'(SKIP_RESET >> 8);
    for (int i = 0; i < 4; i++) begin
      phase_q[i] = '0;
      level_q[i] = 1'b0;
      vol_q[i] = '0;
    end
    rate_q = '0;
    white_q = 1'b0;
    latch_q = '0;
    shifter_q = 15'h4000;
  endtask

  task automatic apply_register_byte(logic [7:0] v);
    logic [2:0] code;
    logic [1:0] sel;
    logic [9:0] raw;
    logic [31:0] hp;
    code = v[6:4];
    if (v[7]) begin
      case (code)
        3'd0, 3'd2, 3'd4: latch_q = v;
        3'd1, 3'd3, 3'd5: vol_q[2 - (code >> 1)] = 4'd15 - v[3:0];
        CODE_NOISE_CTL: begin
          rate_q = v[1:0];
          white_q = v[2];
        end
        default: vol_q[3] = 4'd15 - v[3:0];
      endcase
    end else if (latch_q != 0) begin
      sel = latch_q[6:5];
      if (sel <= 2) begin
        raw = {v[5:0], latch_q[3:0]};
        hp = 32'(raw) * 32'(scale_q);
        half_q[2 - sel] = (hp > 65535) ? 16'hffff : hp[15:0];
      end
    end
  endtask

  task automatic advance_channels();
    logic [63:0] per;
    logic fb;
    for (int ch = 0; ch < 3; ch++) begin
      per = 64'(half_q[ch]) << 8;
      phase_q[ch] = sat_add32(phase_q[ch], 32'(skip_q));
      if (64'(phase_q[ch]) > per) begin
        phase_q[ch] = 32'(64'(phase_q[ch]) - per);
        level_q[ch] = ~level_q[ch];
      end
    end
    if (vol_q[3] > 0) begin
      case (rate_q)
        2'd0: per = 64'(nbase_q);
        2'd1: per = 64'(nbase_q) << 1;
        2'd2: per = 64'(nbase_q) << 2;
        default: per = 64'(half_q[0]);
      endcase
      phase_q[3] = sat_add32(phase_q[3], 32'(skip_q));
      if (white_q) begin
        per = per << 8;
        if (64'(phase_q[3]) > per) begin
          fb = shifter_q[0] ^ shifter_q[1];
          phase_q[3] = 32'(64'(phase_q[3]) - per);
          level_q[3] = shifter_q[0];
          shifter_q = {fb, shifter_q[14:1]};
        end
      end else begin
        if (level_q[3]) per = per * 10;
        per = per << 8;
        if (64'(phase_q[3]) > per) begin
          phase_q[3] = 32'(64'(phase_q[3]) - per);
          level_q[3] = ~level_q[3];
        end
      end
    end
  endtask

  function automatic logic [7:0] mix_sample();
    int total;
    logic [15:0] prod;
    total = 128;
    for (int ch = 0; ch < 4; ch++)
      total += level_q[ch] ? int'(vol_q[ch]) : -int'(vol_q[ch]);
    if (total > 255) total = 255;
    if (total < 0) total = 0;
    prod = 16'(total) * 16'(mvol_q);
    return prod[15:8];
  endfunction

  task automatic predict_request(psg_in_t item);
    psg_out_t r;
    int n;
    n = 0;
    if (item.op == OP_WRITE) begin
      apply_register_byte(item.data_byte);
      return;
    end
    acc_q = sat_add32(acc_q, {16'd0, item.data_byte, 8'd0});
    if (mvol_q == 0) return;
    while (n < MAX_SAMPLES && acc_q >= 32'(skip_q)) begin
      acc_q = acc_q - 32'(skip_q);
      advance_channels();
      r.sample = mix_sample();
      r.last = 1'b0;
      sample_queue.push_back(r);
      n++;
    end
    if (n > 0) sample_queue[$].last = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stall pattern on the result side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold) out_stall <= 1'b0;
      else if ($urandom_range(0, 60) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        out_stall <= 1'b0;
      end else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      samples_seen++;
      if (sample_queue.size() == 0) begin
        $error("unexpected sample %0h last %0b", out_data.sample, out_data.last);
        errors++;
      end else begin
        if (out_data.sample !== sample_queue[0].sample) begin
          $error("sample expected %0h actual %0h", sample_queue[0].sample, out_data.sample);
          errors++;
        end
        if (out_data.last !== sample_queue[0].last) begin
          $error("last expected %0b actual %0b", sample_queue[0].last, out_data.last);
          errors++;
        end
        void'(sample_queue.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("Mismatches found");
      $finish;
    end
  end

  // valid stays high into the next request when no gap follows
  task automatic send_item(logic op, logic [7:0] b);
    psg_in_t item;
    int gap;
    item.op = op;
    item.data_byte = b;
    gap = rnd_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    predict_request(item);
    if (op == OP_TICK) ticks_sent++;
    else writes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [19:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SKIP: skip_q = val;
      CFG_SCALE: scale_q = val[6:0];
      CFG_NOISE: nbase_q = val[13:0];
      default: mvol_q = val[7:0];
    endcase
  endtask

  task automatic write_byte(logic [7:0] b);
    send_item(OP_WRITE, b);
  endtask

  task automatic tick(logic [7:0] b);
    send_item(OP_TICK, b);
  endtask

  task automatic test_defaults();
    write_byte(8'h05);
    tick(8'd0);
    tick(8'd255);
    tick(8'd45);
  endtask

  task automatic test_volumes_and_tones();
    write_byte(8'h90);
    write_byte(8'hb3);
    write_byte(8'hd7);
    write_byte(8'hf0);
    write_byte(8'h8f);
    write_byte(8'h3f);
    write_byte(8'ha1);
    write_byte(8'h00);
    write_byte(8'hc5);
    write_byte(8'h12);
    write_byte(8'he7);
    tick(8'd255);
    write_byte(8'he3);
    write_byte(8'he4);
    tick(8'd200);
    write_byte(8'hff);
    tick(8'd100);
  endtask

  task automatic test_extremes();
    write_cfg(CFG_SKIP, 20'd1024);
    write_cfg(CFG_SCALE, 20'd64);
    write_cfg(CFG_NOISE, 20'd1);
    write_byte(8'h8f);
    write_byte(8'h3f);
    write_byte(8'hf0);
    write_byte(8'he6);
    tick(8'd255);
    tick(8'd255);
    write_cfg(CFG_MASTER, 20'd0);
    tick(8'd255);
    tick(8'd128);
    write_cfg(CFG_MASTER, 20'd1);
    tick(8'd1);
    write_cfg(CFG_SKIP, 20'hfffff);
    write_cfg(CFG_NOISE, 20'd16383);
    write_cfg(CFG_SCALE, 20'd1);
    tick(8'd255);
  endtask

  task automatic random_phase(int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          b = 8'h80 | 8'($urandom_range(0, 2) << 5) | 8'($urandom_range(0, 15));
          write_byte(b);
          write_byte(8'($urandom_range(0, 255)) & 8'h7f);
        end
        2: write_byte(8'($urandom_range(0, 255)));
        default: tick(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    errors = 0;
    samples_seen = 0;
    ticks_sent = 0;
    writes_sent = 0;
    idle_cycles = 0;
    stall_hold = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    predictor_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_volumes_and_tones();
    test_extremes();
    write_cfg(CFG_SKIP, 20'd3000);
    write_cfg(CFG_SCALE, 20'd3);
    write_cfg(CFG_NOISE, 20'd40);
    write_cfg(CFG_MASTER, 20'd255);
    random_phase(120);
    write_cfg(CFG_SKIP, 20'($urandom_range(1024, 8000)));
    write_cfg(CFG_SCALE, 20'($urandom_range(1, 64)));
    write_cfg(CFG_NOISE, 20'($urandom_range(1, 300)));
    write_cfg(CFG_MASTER, 20'($urandom_range(1, 255)));
    random_phase(120);
    write_cfg(CFG_SKIP, 20'($urandom_range(1024, 1048575)));
    write_cfg(CFG_MASTER, 20'($urandom_range(0, 255)));
    random_phase(60);
    in_valid <= 1'b0;
    stall_hold = 1'b1;
    while (sample_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d ticks and %0d register bytes, %0d samples checked",
             ticks_sent, writes_sent, samples_seen);
    $display("configuration extremes, master volume zero and both noise modes exercised");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
